// ===== rtl/c5_pkg.sv =====
package c5_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int KSIZE     = 5;
  localparam int MEM_ROWS  = KSIZE - 1;
  localparam int PIX_W     = 24;
  localparam int ACC_W     = 22;
  localparam int PROD_W    = 36;

  // register indexes on the configuration port
  localparam logic [2:0] REG_KROW0 = 3'd0;
  localparam logic [2:0] REG_KROW1 = 3'd1;
  localparam logic [2:0] REG_KROW2 = 3'd2;
  localparam logic [2:0] REG_KROW3 = 3'd3;
  localparam logic [2:0] REG_KROW4 = 3'd4;
  localparam logic [2:0] REG_MULT  = 3'd5;
  localparam logic [2:0] REG_SHIFT = 3'd6;
  localparam logic [2:0] REG_WIDTH = 3'd7;

  typedef struct packed {
    logic [KSIZE-1:0][39:0] kernel;
    logic [15:0]            mult;
    logic [4:0]             shift;
    logic [11:0]            width;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic shift;
    logic mac_en;
    logic mul;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic produce;
    logic tap_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/c5_cfg.sv =====
module c5_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [5:0]      cfg_paddr,
  input  logic [63:0]     cfg_pwdata,
  output logic [63:0]     cfg_prdata,
  output logic            cfg_pready,
  output c5_pkg::cfg_t    cfg
);
  import c5_pkg::*;

  cfg_t       regs_r;
  logic       wr;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx = cfg_paddr[5:3];
  assign cfg = regs_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // identity kernel: only the center tap of row 2 is set
      regs_r.kernel    <= {40'd0, 40'd0, 40'h10000, 40'd0, 40'd0};
      regs_r.mult      <= 16'd1;
      regs_r.shift     <= 5'd0;
      regs_r.width     <= 12'd2048;
    end else if (wr) begin
      unique case (idx)
        REG_KROW0, REG_KROW1, REG_KROW2, REG_KROW3, REG_KROW4:
          regs_r.kernel[idx] <= cfg_pwdata[39:0];
        REG_MULT:  regs_r.mult  <= cfg_pwdata[15:0];
        REG_SHIFT: regs_r.shift <= cfg_pwdata[4:0];
        REG_WIDTH: regs_r.width <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_KROW0, REG_KROW1, REG_KROW2, REG_KROW3, REG_KROW4:
        cfg_prdata = {24'd0, regs_r.kernel[idx]};
      REG_MULT:  cfg_prdata = {48'd0, regs_r.mult};
      REG_SHIFT: cfg_prdata = {59'd0, regs_r.shift};
      REG_WIDTH: cfg_prdata = {52'd0, regs_r.width};
      default:   cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/c5_ctrl.sv =====
module c5_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  c5_pkg::stat_t stat,
  output c5_pkg::cmd_t  cmd
);
  import c5_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHIFT = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_RND   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.accept = in_tready & in_tvalid;
  assign cmd.shift  = (state_r == ST_SHIFT);
  assign cmd.mac_en = (state_r == ST_MAC);
  assign cmd.mul    = (state_r == ST_MUL);
  assign cmd.load   = (state_r == ST_RND) & ~stat.out_busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = stat.produce ? ST_MAC : ST_IDLE;
      ST_MAC:   if (stat.tap_last) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_RND;
      ST_RND:   if (!stat.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/c5_dp.sv =====
module c5_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  c5_pkg::cfg_t  cfg,
  input  c5_pkg::cmd_t  cmd,
  output c5_pkg::stat_t stat,
  input  logic [23:0]   in_pix,
  input  logic          in_fs,
  output logic [23:0]   out_pix,
  output logic          out_last,
  output logic          out_valid,
  input  logic          out_ready
);
  import c5_pkg::*;

  // rounding with ties to even, then clamp to a byte
  function automatic logic [7:0] round_clamp(input logic [PROD_W-1:0] p,
                                             input logic [4:0] sh);
    logic [PROD_W-1:0] q, mask, rem, half;
    logic              up;
    q    = p >> sh;
    mask = (PROD_W'(1) << sh) - PROD_W'(1);
    rem  = p & mask;
    half = (sh == 5'd0) ? '0 : (PROD_W'(1) << (sh - 5'd1));
    up   = (sh != 5'd0) && ((rem > half) || ((rem == half) && q[0]));
    q    = q + PROD_W'(up);
    return (q > PROD_W'(255)) ? 8'hFF : q[7:0];
  endfunction

  logic [MEM_ROWS*PIX_W-1:0] mem [MAX_WIDTH];
  logic [MEM_ROWS*PIX_W-1:0] mem_q_r;
  logic [PIX_W-1:0]          win_r [KSIZE][KSIZE];
  logic [PIX_W-1:0]          pix_r;
  logic [COL_W-1:0]          col_cnt_r, col_r, col_base, col_eff;
  logic [2:0]                row_r, row_eff;
  logic                      prod_r, last_r, wrap;
  logic [11:0]               w_eff;
  logic [2:0]                tr_r, tc_r;
  logic signed [ACC_W-1:0]   acc_r [3];
  logic [PROD_W-1:0]         p_r [3];
  logic [39:0]               krow;
  logic signed [7:0]         coef;
  logic [PIX_W-1:0]          tap;
  logic [23:0]               out_pix_r;
  logic                      out_last_r, out_valid_r;

  // effective line width and counter handling
  always_comb begin
    if (cfg.width < 12'd5)                 w_eff = 12'd5;
    else if (cfg.width > 12'(MAX_WIDTH))   w_eff = 12'(MAX_WIDTH);
    else                                   w_eff = cfg.width;
    col_base = in_fs ? '0 : col_cnt_r;
    col_eff  = ({1'b0, col_base} >= w_eff) ? '0 : col_base;
    row_eff  = in_fs ? 3'd0 : row_r;
    wrap     = ({1'b0, col_eff} + 12'd1) >= w_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_r     <= '0;
    end else if (cmd.accept) begin
      col_cnt_r <= wrap ? '0 : col_eff + COL_W'(1);
      row_r     <= (wrap && row_eff < 3'd4) ? row_eff + 3'd1 : row_eff;
    end
  end

  // item latch and line store read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r   <= in_pix;
      col_r   <= col_eff;
      prod_r  <= (row_eff == 3'd4) && (col_eff >= COL_W'(4));
      last_r  <= ({1'b0, col_eff} == (w_eff - 12'd1));
      mem_q_r <= mem[col_eff];
    end
  end

  // line store write: oldest slot drops out, new pixel goes in on top
  always_ff @(posedge clk) begin
    if (cmd.shift)
      mem[col_r] <= {pix_r, mem_q_r[MEM_ROWS*PIX_W-1:PIX_W]};
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < KSIZE; r++)
        for (int c = 0; c < KSIZE; c++)
          win_r[r][c] <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < KSIZE; r++) begin
        for (int c = 0; c < KSIZE - 1; c++)
          win_r[r][c] <= win_r[r][c+1];
        win_r[r][KSIZE-1] <= (r < MEM_ROWS) ? mem_q_r[r*PIX_W +: PIX_W] : pix_r;
      end
    end
  end

  // one tap per cycle, three channels side by side
  always_comb begin
    krow = cfg.kernel[tr_r];
    coef = signed'(krow[{tc_r, 3'b000} +: 8]);
    tap  = win_r[tr_r][tc_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      tr_r <= '0;
      tc_r <= '0;
      for (int ch = 0; ch < 3; ch++) acc_r[ch] <= '0;
    end else if (cmd.mac_en) begin
      if (tc_r == 3'(KSIZE - 1)) begin
        tc_r <= '0;
        tr_r <= tr_r + 3'd1;
      end else begin
        tc_r <= tc_r + 3'd1;
      end
      for (int ch = 0; ch < 3; ch++)
        acc_r[ch] <= acc_r[ch] +
                     ACC_W'(coef) * ACC_W'(signed'({1'b0, tap[ch*8 +: 8]}));
    end
  end

  // scale by the multiplier
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int ch = 0; ch < 3; ch++)
        p_r[ch] <= (acc_r[ch] > 0) ?
                   PROD_W'(acc_r[ch][19:0]) * PROD_W'(cfg.mult) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int ch = 0; ch < 3; ch++)
        out_pix_r[ch*8 +: 8] <= round_clamp(p_r[ch], cfg.shift);
      out_last_r <= last_r;
    end
  end

  assign out_pix       = out_pix_r;
  assign out_last      = out_last_r;
  assign out_valid     = out_valid_r;
  assign stat.produce  = prod_r;
  assign stat.tap_last = (tr_r == 3'(KSIZE - 1)) && (tc_r == 3'(KSIZE - 1));
  assign stat.out_busy = out_valid_r & ~out_ready;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.shift && (cmd.mac_en || cmd.accept)))
    else $error("window shift overlaps another step");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a waiting one");
  a_accept_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.shift)
    else $error("accepted item not shifted in");
  a_mac_produce: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && !prod_r) |=> !cmd.mac_en)
    else $error("sum started for an item without result");

endmodule

// ===== rtl/conv5x5_rgb_stream.sv =====
// channel  dir  handshake                 tdata                 tuser / tlast
// in_      in   in_tvalid / in_tready     red, green, blue      tuser: frame_start
// out_     out  out_tvalid / out_tready   red, green, blue      tlast: row_end
// cfg_     in   apb, pready tied high     64-bit regs at 8*i    -
//
// an item without result goes through line store read and window shift;
// an item with result goes through those two, then 25 multiply-accumulate
// steps (one kernel tap a cycle, three channels in parallel), scale, round
// reset (rst_n, synchronous) clears column and row counters, window, fsm and output valid;
// the line store is not cleared and is filled by the first four lines
// a stalled output holds the block in its round step until the result is taken
module conv5x5_rgb_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_red, out_green, out_blue
  output logic        out_tlast,  // row_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import c5_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  c5_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready), .cfg(cfg)
  );

  c5_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  c5_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .cmd(cmd), .stat(stat),
    .in_pix(in_tdata), .in_fs(in_tuser),
    .out_pix(out_tdata), .out_last(out_tlast),
    .out_valid(out_tvalid), .out_ready(out_tready)
  );

endmodule

// ===== tb/conv5x5_rgb_stream_checker.sv =====
`timescale 1ns / 1ps
module conv5x5_rgb_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_pixels
);
  import c5_pkg::*;

  typedef struct packed {
    logic [23:0] rgb;
    logic        row_end;
  } conv_pix_t;

  logic [39:0] krow [KSIZE];
  logic [15:0] mult;
  logic [4:0]  shamt;
  logic [11:0] width;
  logic [23:0] line_mem [4*MAX_WIDTH];
  logic [23:0] win [KSIZE][KSIZE];
  int          col_cnt, row_cnt;
  conv_pix_t   expected_pixels [$];

  assign pending_pixels = expected_pixels.size();

  // one channel: 25 taps, scale, round half to even, clamp
  function automatic logic [7:0] filter_channel(int lsb);
    longint sum;
    logic [63:0] p, q, rem, half;
    logic signed [7:0] k;
    sum = 0;
    for (int r = 0; r < KSIZE; r++)
      for (int c = 0; c < KSIZE; c++) begin
        k = krow[r][8*c +: 8];
        sum += longint'(k) * longint'(win[r][c][lsb +: 8]);
      end
    if (sum <= 0) return 8'd0;
    p = 64'(sum) * 64'(mult);
    if (shamt == 0) q = p;
    else begin
      q = p >> shamt;
      rem = p & ((64'd1 << shamt) - 1);
      half = 64'd1 << (shamt - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // predict on every accepted pixel
  task automatic predict_pixel(logic [23:0] pix, logic fs);
    int w, col, base;
    conv_pix_t e;
    w = (width < 5) ? 5 : (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    col = col_cnt;
    base = col * 4;
    for (int r = 0; r < KSIZE; r++)
      for (int c = 0; c < KSIZE - 1; c++) win[r][c] = win[r][c+1];
    for (int r = 0; r < 4; r++) win[r][4] = line_mem[base + r];
    win[4][4] = pix;
    for (int r = 0; r < 3; r++) line_mem[base + r] = line_mem[base + r + 1];
    line_mem[base + 3] = pix;
    if (row_cnt >= 4 && col >= 4) begin
      e.rgb = {filter_channel(16), filter_channel(8), filter_channel(0)};
      e.row_end = (col == w - 1);
      expected_pixels.push_back(e);
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt < 4) row_cnt++;
    end else col_cnt = col + 1;
  endtask

  always @(posedge clk) begin
    conv_pix_t e;
    if (!rst_n) begin
      for (int r = 0; r < KSIZE; r++) krow[r] <= (r == 2) ? 40'h10000 : 40'd0;
      mult <= 16'd1;
      shamt <= '0;
      width <= 12'd2048;
      for (int r = 0; r < KSIZE; r++)
        for (int c = 0; c < KSIZE; c++) win[r][c] = '0;
      for (int i = 0; i < 4*MAX_WIDTH; i++) line_mem[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      fail_count <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[5:3])
          REG_KROW0, REG_KROW1, REG_KROW2, REG_KROW3, REG_KROW4:
            krow[cfg_paddr[5:3]] <= cfg_pwdata[39:0];
          REG_MULT:  mult <= cfg_pwdata[15:0];
          REG_SHIFT: shamt <= cfg_pwdata[4:0];
          REG_WIDTH: width <= cfg_pwdata[11:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_pixel(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %h/%b",
                   $time, out_tdata, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_pixels.pop_front();
          if (out_tdata !== e.rgb || out_tlast !== e.row_end) begin
            $display("%0t: mismatch, expected %h/%b, actual %h/%b",
                     $time, e.rgb, e.row_end, out_tdata, out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/conv5x5_rgb_stream_tb.sv =====
`timescale 1ns / 1ps
module conv5x5_rgb_stream_tb;
  import c5_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [23:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending_pixels;
  int          send_idle_pct, recv_stall_pct;
  longint      cycle_count;

  conv5x5_rgb_stream uut (.*);
  conv5x5_rgb_stream_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 3'b000}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(negedge clk);
  endtask

  // valid stays high after the item; the caller or the next idle drops it
  task automatic send_pixel(logic [23:0] pix, logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1; in_tdata <= pix; in_tuser <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain results, then let the last no-result item finish
  task automatic wait_idle();
    while (pending_pixels != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic random_kernel(int mode);
    logic [39:0] row;
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++)
        case (mode)
          0: row[8*c +: 8] = 8'h7f;
          1: row[8*c +: 8] = 8'h80;
          default: row[8*c +: 8] = 8'($urandom_range(255));
        endcase
      write_reg(3'(r), {24'($urandom), row});
    end
  endtask

  // one frame of h lines, w wide; noise pixels are random
  task automatic send_frame(int w, int h, int style);
    logic [23:0] p;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        case (style)
          0: p = 24'hffffff;
          1: p = 24'h000000;
          default: p = 24'($urandom);
        endcase
        send_pixel(p, (x == 0 && y == 0));
      end
    in_tvalid <= 0;
    @(negedge clk);
  endtask

  int n_items;
  int w, h;

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: identity at reset, narrowest width, extreme kernels
    write_reg(REG_WIDTH, 64'd5);
    send_frame(5, 5, 2);
    wait_idle();
    random_kernel(0);
    write_reg(REG_MULT, 64'hffff);
    write_reg(REG_SHIFT, 64'd0);
    send_frame(5, 5, 0);
    wait_idle();
    random_kernel(1);
    write_reg(REG_MULT, 64'd0);
    write_reg(REG_SHIFT, 64'd31);
    write_reg(REG_WIDTH, 64'd3);
    send_frame(5, 5, 0);
    wait_idle();

    // random frames over the idling phases
    n_items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 32 : 0;
      recv_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 32 : 0;
      for (int f = 0; f < 4; f++) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(20, 30) : $urandom_range(5, 9);
        h = $urandom_range(5, 8);
        random_kernel(2);
        write_reg(REG_MULT, ($urandom_range(3) == 0) ? 64'($urandom)
                                                   : 64'($urandom_range(1, 16)));
        write_reg(REG_SHIFT, ($urandom_range(3) == 0) ? 64'($urandom)
                                                    : 64'($urandom_range(0, 10)));
        write_reg(REG_WIDTH, {52'($urandom), 12'(w)});
        if ($urandom_range(4) == 0) begin
          // broken frame: restart midway, then full frame
          send_frame(w, 2, 2);
        end
        send_frame(w, h, 2);
        n_items += w * h;
        wait_idle();
      end
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    // width above maximum acts as maximum; rewrite one legal width at the end
    write_reg(REG_WIDTH, 64'hfff);
    write_reg(REG_WIDTH, 64'd6);
    while (n_items < 1650) begin
      send_frame(6, 5, 2);
      n_items += 30;
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
